// ===== rtl/pgw_pkg.sv =====
package pgw_pkg;

  localparam int unsigned TABLE_WORDS_DEF = 4096;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // Page kinds
  localparam logic [1:0] KIND_4K = 2'd0;
  localparam logic [1:0] KIND_2M = 2'd1;
  localparam logic [1:0] KIND_1G = 2'd2;

  // Large-page flag position in an entry
  localparam int unsigned LARGE_BIT = 7;

  typedef struct packed {
    logic        opcode;
    logic [11:0] word_index;
    logic [63:0] word_data;
    logic [47:0] virtual_addr;
  } in_item_t;

  typedef struct packed {
    logic [51:0] physical_addr;
    logic [1:0]  page_kind;
    logic        range_error;
  } out_item_t;

endpackage

// ===== rtl/pgw_table_mem.sv =====
module pgw_table_mem #(
  parameter int unsigned TABLE_WORDS = pgw_pkg::TABLE_WORDS_DEF,
  localparam int unsigned AW = $clog2(TABLE_WORDS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o
);

  logic [63:0] mem [TABLE_WORDS];
  logic [63:0] rd_data_q;

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/four_level_page_walker.sv =====
// Four-level page table walker for 48-bit virtual addresses. Page tables live in an
// internal table memory of TABLE_WORDS 64-bit words (word w at physical byte 8*w),
// filled by write items (opcode 0) that give no result. A translate item (opcode 1)
// walks from root_base, the last value on cfg_wdata_i with cfg_we_i high (low 12
// bits ignored). Items transfer on start_i high with busy_o low. busy_o stays low
// after a write and the next item can transfer right away. A translate does one
// table memory read per level, each needing the entry before it, so busy_o is
// high while those reads run (it stays low when the root address is already out
// of range), and no new item transfers until the walk ends. The result is on
// result_o for exactly one cycle with valid_o high, the cycle after the walk ends;
// the receiver cannot stall it, so it must take every strobe. A table address at or
// beyond TABLE_WORDS ends the walk with range_error set, physical_addr zero and
// page_kind 4K. Present bits are not checked. Reading a table word that was never
// written returns undefined data.
module four_level_page_walker #(
  parameter int unsigned TABLE_WORDS = pgw_pkg::TABLE_WORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pgw_pkg::in_item_t  item_i,
  input  logic               cfg_we_i,
  input  logic [51:0]        cfg_wdata_i,
  output logic               valid_o,
  output pgw_pkg::out_item_t result_o
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);
  // word addresses are {table base bits 51:12, 9-bit index}: 49 bits
  localparam logic [48:0] TW_LIMIT = 49'(TABLE_WORDS);

  // walk sequencer: state names the level whose entry is on the read port
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_L4   = 3'd1;
  localparam logic [2:0] ST_L3   = 3'd2;
  localparam logic [2:0] ST_L2   = 3'd3;
  localparam logic [2:0] ST_L1   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [39:0] root_q;
  logic [47:0] va_q, va_d;
  logic        valid_q, valid_d;
  pgw_pkg::out_item_t res_q, res_d;

  logic        accept;
  logic        mem_we, mem_rd_en;
  logic [63:0] entry;
  logic [39:0] walk_base;
  logic [8:0]  walk_idx;
  logic [48:0] walk_addr;
  logic        walk_err;
  logic [48:0] wr_word;
  logic        wr_in_range;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // root table base; the low 12 bits of cfg_wdata_i are ignored and not kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i[51:12];
    end
  end

  // next table address: from the root in idle, else from the entry just read
  always_comb begin
    walk_base = entry[51:12];
    walk_idx  = va_q[38:30];
    case (state_q)
      ST_IDLE: begin
        walk_base = root_q;
        walk_idx  = item_i.virtual_addr[47:39];
      end
      ST_L4:   walk_idx = va_q[38:30];
      ST_L3:   walk_idx = va_q[29:21];
      ST_L2:   walk_idx = va_q[20:12];
      default: walk_idx = va_q[38:30];
    endcase
  end

  assign walk_addr = {walk_base, walk_idx};
  assign walk_err  = (walk_addr >= TW_LIMIT);

  // write port: word_index beyond the memory is dropped
  assign wr_word     = 49'(item_i.word_index);
  assign wr_in_range = (wr_word < TW_LIMIT);

  always_comb begin
    state_d   = state_q;
    va_d      = va_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_rd_en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.opcode == pgw_pkg::OP_WRITE) begin
            mem_we = wr_in_range;
          end else begin
            va_d = item_i.virtual_addr;
            if (walk_err) begin
              valid_d = 1'b1;
              res_d   = '{physical_addr: '0, page_kind: pgw_pkg::KIND_4K, range_error: 1'b1};
            end else begin
              mem_rd_en = 1'b1;
              state_d   = ST_L4;
            end
          end
        end
      end
      ST_L4: begin
        if (walk_err) begin
          valid_d = 1'b1;
          res_d   = '{physical_addr: '0, page_kind: pgw_pkg::KIND_4K, range_error: 1'b1};
          state_d = ST_IDLE;
        end else begin
          mem_rd_en = 1'b1;
          state_d   = ST_L3;
        end
      end
      ST_L3: begin
        if (entry[pgw_pkg::LARGE_BIT]) begin
          // 1G page
          valid_d = 1'b1;
          res_d   = '{physical_addr: {entry[51:30], va_q[29:0]},
                      page_kind: pgw_pkg::KIND_1G, range_error: 1'b0};
          state_d = ST_IDLE;
        end else if (walk_err) begin
          valid_d = 1'b1;
          res_d   = '{physical_addr: '0, page_kind: pgw_pkg::KIND_4K, range_error: 1'b1};
          state_d = ST_IDLE;
        end else begin
          mem_rd_en = 1'b1;
          state_d   = ST_L2;
        end
      end
      ST_L2: begin
        if (entry[pgw_pkg::LARGE_BIT]) begin
          // 2M page
          valid_d = 1'b1;
          res_d   = '{physical_addr: {entry[51:21], va_q[20:0]},
                      page_kind: pgw_pkg::KIND_2M, range_error: 1'b0};
          state_d = ST_IDLE;
        end else if (walk_err) begin
          valid_d = 1'b1;
          res_d   = '{physical_addr: '0, page_kind: pgw_pkg::KIND_4K, range_error: 1'b1};
          state_d = ST_IDLE;
        end else begin
          mem_rd_en = 1'b1;
          state_d   = ST_L1;
        end
      end
      ST_L1: begin
        valid_d = 1'b1;
        res_d   = '{physical_addr: {entry[51:12], va_q[11:0]},
                    page_kind: pgw_pkg::KIND_4K, range_error: 1'b0};
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    va_q  <= va_d;
    res_q <= res_d;
  end

  pgw_table_mem #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_table_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (wr_word[AW-1:0]),
    .wr_data_i (item_i.word_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (walk_addr[AW-1:0]),
    .rd_data_o (entry)
  );

  assign valid_o  = valid_q;
  assign result_o = res_q;

  // a result strobe follows a walk step or a translate transfer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(busy_o) || $past(start_i && item_i.opcode == pgw_pkg::OP_XLATE)))
    else $error("result strobe without a walk");

  // the last level always produces a good 4K result
  a_l1_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_L1) |=> (valid_o && !result_o.range_error &&
                            result_o.page_kind == pgw_pkg::KIND_4K && !busy_o))
    else $error("level-1 step did not finish the walk");

  // table writes and walk reads never share a cycle
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_rd_en))
    else $error("table write and read in the same cycle");

  // a table write gives no result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.opcode == pgw_pkg::OP_WRITE) |=> (!valid_o && !busy_o))
    else $error("write transfer produced a result");

  // a range error always carries a zero address
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.range_error) |-> (result_o.physical_addr == '0))
    else $error("range error with nonzero address");

endmodule
